### sv/rmq_pkg.sv
// Shared types, widths and helper functions for the rotation matrix to
// quaternion pipeline. Used by every module of the block; no dependencies.
package rmq_pkg;

   localparam int DATA_W    = 16;
   localparam int FRAC_BITS = 14;
   // diagonal sums with the constant one added
   localparam int SUM_W     = DATA_W + 3;
   // off-diagonal pair sums and differences
   localparam int DIFF_W    = DATA_W + 1;
   localparam int MAG_W     = DIFF_W;
   // square-root radicand, even width
   localparam int RAD_W     = 2 * ((SUM_W + FRAC_BITS) / 2);
   localparam int ROOT_W    = RAD_W / 2;
   // divide numerator and quotient; the root of a positive radicand is at
   // least 2^(FRAC_BITS/2), which bounds the quotient width
   localparam int NUM_W     = MAG_W + FRAC_BITS;
   localparam int RMIN_W    = FRAC_BITS / 2;
   localparam int QUO_W     = NUM_W - RMIN_W;
   localparam int REM_W     = ROOT_W + 1;

   localparam logic [QUO_W-1:0] MAX_POS = QUO_W'((64'd1 << (DATA_W - 1)) - 64'd1);

   typedef enum logic [1:0] {
      SEL_X = 2'd0,
      SEL_Y = 2'd1,
      SEL_Z = 2'd2,
      SEL_W = 2'd3
   } sel_type;

   typedef logic signed [DATA_W-1:0] elem_type;
   typedef logic signed [DIFF_W-1:0] diff_type;

   // front end to square root
   typedef struct packed {
      logic               invalid;
      sel_type            sel;
      diff_type           d0;
      diff_type           d1;
      diff_type           d2;
      logic [RAD_W-1:0]   rad;
   } front_type;

   // square root to divider
   typedef struct packed {
      logic               invalid;
      sel_type            sel;
      diff_type           d0;
      diff_type           d1;
      diff_type           d2;
      logic [ROOT_W-1:0]  root;
   } root_type;

   // divider to output stage
   typedef struct packed {
      logic               invalid;
      sel_type            sel;
      logic [ROOT_W-1:0]  root;
      logic               neg0;
      logic               neg1;
      logic               neg2;
      logic [QUO_W-1:0]   quo0;
      logic [QUO_W-1:0]   quo1;
      logic [QUO_W-1:0]   quo2;
   } div_type;

   typedef struct packed {
      logic               invalid;
      elem_type           q_x;
      elem_type           q_y;
      elem_type           q_z;
      elem_type           q_w;
   } result_type;

   // apply sign and saturate a magnitude to the output range
   function automatic elem_type sat_term(input logic neg, input logic [QUO_W-1:0] mag);
      logic [QUO_W-1:0] negmag;
      elem_type         res;
      negmag = ~mag + QUO_W'(1);
      if (!neg) begin
         res = (mag > MAX_POS) ? elem_type'(MAX_POS[DATA_W-1:0]) : mag[DATA_W-1:0];
      end else begin
         res = (mag > MAX_POS + QUO_W'(1)) ? {1'b1, {(DATA_W-1){1'b0}}}
                                           : negmag[DATA_W-1:0];
      end
      return res;
   endfunction

   // place the half root and the three scaled terms by branch
   function automatic result_type build_result(input div_type d);
      result_type       res;
      logic [ROOT_W:0]  half_w;
      elem_type         h;
      elem_type         c0;
      elem_type         c1;
      elem_type         c2;
      half_w = ({1'b0, d.root} + (ROOT_W+1)'(1)) >> 1;
      h  = sat_term(1'b0, QUO_W'(half_w));
      c0 = sat_term(d.neg0, d.quo0);
      c1 = sat_term(d.neg1, d.quo1);
      c2 = sat_term(d.neg2, d.quo2);
      res.invalid = d.invalid;
      case (d.sel)
         SEL_W: begin
            res.q_x = c0; res.q_y = c1; res.q_z = c2; res.q_w = h;
         end
         SEL_X: begin
            res.q_x = h; res.q_y = c0; res.q_z = c1; res.q_w = c2;
         end
         SEL_Y: begin
            res.q_x = c0; res.q_y = h; res.q_z = c1; res.q_w = c2;
         end
         default: begin
            res.q_x = c0; res.q_y = c1; res.q_z = h; res.q_w = c2;
         end
      endcase
      if (d.invalid) begin
         res.q_x = '0; res.q_y = '0; res.q_z = '0; res.q_w = '0;
      end
      return res;
   endfunction

endpackage

### sv/rmq_front.sv
// First pipeline stage: branch choice, radicand and off-diagonal terms.
// Depends on rmq_pkg.
module rmq_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  rmq_pkg::elem_type m_xx,
   input  rmq_pkg::elem_type m_xy,
   input  rmq_pkg::elem_type m_xz,
   input  rmq_pkg::elem_type m_yx,
   input  rmq_pkg::elem_type m_yy,
   input  rmq_pkg::elem_type m_yz,
   input  rmq_pkg::elem_type m_zx,
   input  rmq_pkg::elem_type m_zy,
   input  rmq_pkg::elem_type m_zz,
   output logic             out_valid,
   output rmq_pkg::front_type out_word
);
   import rmq_pkg::*;

   typedef logic signed [SUM_W-1:0] sum_type;

   localparam sum_type ONE = sum_type'(64'd1 << FRAC_BITS);

   sum_type   xx, yy, zz, trace, s;
   front_type word_in;
   front_type word_ff;
   logic      v_ff;

   assign xx    = sum_type'(m_xx);
   assign yy    = sum_type'(m_yy);
   assign zz    = sum_type'(m_zz);
   assign trace = xx + yy + zz;

   // pick the branch and form its sums
   always_comb begin
      if (trace > 0) begin
         word_in.sel = SEL_W;
         s          = ONE + trace;
         word_in.d0 = diff_type'(m_zy) - diff_type'(m_yz);
         word_in.d1 = diff_type'(m_xz) - diff_type'(m_zx);
         word_in.d2 = diff_type'(m_yx) - diff_type'(m_xy);
      end else if (m_xx > m_yy && m_xx > m_zz) begin
         word_in.sel = SEL_X;
         s          = ONE + xx - yy - zz;
         word_in.d0 = diff_type'(m_yx) + diff_type'(m_xy);
         word_in.d1 = diff_type'(m_xz) + diff_type'(m_zx);
         word_in.d2 = diff_type'(m_zy) - diff_type'(m_yz);
      end else if (m_yy > m_zz) begin
         word_in.sel = SEL_Y;
         s          = ONE + yy - xx - zz;
         word_in.d0 = diff_type'(m_yx) + diff_type'(m_xy);
         word_in.d1 = diff_type'(m_zy) + diff_type'(m_yz);
         word_in.d2 = diff_type'(m_xz) - diff_type'(m_zx);
      end else begin
         word_in.sel = SEL_Z;
         s          = ONE + zz - xx - yy;
         word_in.d0 = diff_type'(m_xz) + diff_type'(m_zx);
         word_in.d1 = diff_type'(m_zy) + diff_type'(m_yz);
         word_in.d2 = diff_type'(m_yx) - diff_type'(m_xy);
      end
      word_in.invalid = (s <= 0);
      word_in.rad     = RAD_W'(s[SUM_W-2:0]) << FRAC_BITS;
   end

   // hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_valid;
      end
      if (en) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = v_ff;
   assign out_word  = word_ff;

endmodule

### sv/rmq_sqrt.sv
// Integer square root, one result bit per pipeline stage.
// Depends on rmq_pkg.
module rmq_sqrt (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  rmq_pkg::front_type in_word,
   output logic               out_valid,
   output rmq_pkg::root_type  out_word
);
   import rmq_pkg::*;

   logic              v_src   [ROOT_W];
   logic [RAD_W-1:0]  rem_src [ROOT_W];
   logic [RAD_W-1:0]  res_src [ROOT_W];
   front_type         pay_src [ROOT_W];
   logic              v_ff    [ROOT_W];
   logic [RAD_W-1:0]  rem_ff  [ROOT_W];
   logic [RAD_W-1:0]  res_ff  [ROOT_W];
   front_type         pay_ff  [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      localparam logic [RAD_W-1:0] BITV = RAD_W'(64'd1 << (RAD_W - 2 - 2 * k));

      logic [RAD_W-1:0] trial;
      logic [RAD_W-1:0] rem_in;
      logic [RAD_W-1:0] res_in;

      if (k == 0) begin : g_first
         assign v_src[k]   = in_valid;
         assign rem_src[k] = in_word.rad;
         assign res_src[k] = '0;
         assign pay_src[k] = in_word;
      end else begin : g_next
         assign v_src[k]   = v_ff[k-1];
         assign rem_src[k] = rem_ff[k-1];
         assign res_src[k] = res_ff[k-1];
         assign pay_src[k] = pay_ff[k-1];
      end

      // try one root bit
      always_comb begin
         trial = res_src[k] + BITV;
         if (rem_src[k] >= trial) begin
            rem_in = rem_src[k] - trial;
            res_in = (res_src[k] >> 1) + BITV;
         end else begin
            rem_in = rem_src[k];
            res_in = res_src[k] >> 1;
         end
      end

      // advance when enabled
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_src[k];
         end
         if (en) begin
            rem_ff[k] <= rem_in;
            res_ff[k] <= res_in;
            pay_ff[k] <= pay_src[k];
         end
      end
   end

   assign out_valid        = v_ff[ROOT_W-1];
   assign out_word.invalid = pay_ff[ROOT_W-1].invalid;
   assign out_word.sel     = pay_ff[ROOT_W-1].sel;
   assign out_word.d0      = pay_ff[ROOT_W-1].d0;
   assign out_word.d1      = pay_ff[ROOT_W-1].d1;
   assign out_word.d2      = pay_ff[ROOT_W-1].d2;
   assign out_word.root    = res_ff[ROOT_W-1][ROOT_W-1:0];

endmodule

### sv/rmq_div.sv
// Three-lane restoring divider, one quotient bit per stage, that scales the
// off-diagonal terms by the root. Depends on rmq_pkg.
module rmq_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  rmq_pkg::root_type in_word,
   output logic              out_valid,
   output rmq_pkg::div_type  out_word
);
   import rmq_pkg::*;

   localparam int LANES = 3;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [NUM_W-1:0] num;
      logic [QUO_W-1:0] quo;
      logic             neg;
   } lane_type;

   typedef struct packed {
      logic              invalid;
      sel_type           sel;
      logic [ROOT_W-1:0] root;
   } ctl_type;

   diff_type   d_in [LANES];
   lane_type   init [LANES];
   logic       v_src   [QUO_W];
   ctl_type    ctl_src [QUO_W];
   lane_type   ln_src  [QUO_W][LANES];
   logic       v_ff    [QUO_W];
   ctl_type    ctl_ff  [QUO_W];
   lane_type   ln_ff   [QUO_W][LANES];

   assign d_in[0] = in_word.d0;
   assign d_in[1] = in_word.d1;
   assign d_in[2] = in_word.d2;

   // form rounded numerators: |d| * 2^(FRAC_BITS-1) + root/2
   for (genvar j = 0; j < LANES; j++) begin : g_init
      logic [MAG_W-1:0] mag;
      assign mag = d_in[j][DIFF_W-1] ? (~d_in[j] + MAG_W'(1)) : d_in[j];
      assign init[j].num = (NUM_W'(mag) << (FRAC_BITS - 1))
                           + NUM_W'(in_word.root >> 1);
      assign init[j].rem = REM_W'(init[j].num[NUM_W-1:QUO_W]);
      assign init[j].quo = '0;
      assign init[j].neg = d_in[j][DIFF_W-1];
   end

   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      lane_type ln_in [LANES];

      if (k == 0) begin : g_first
         assign v_src[k]       = in_valid;
         assign ctl_src[k].invalid = in_word.invalid;
         assign ctl_src[k].sel     = in_word.sel;
         assign ctl_src[k].root    = in_word.root;
         for (genvar j = 0; j < LANES; j++) begin : g_l
            assign ln_src[k][j] = init[j];
         end
      end else begin : g_next
         assign v_src[k]   = v_ff[k-1];
         assign ctl_src[k] = ctl_ff[k-1];
         for (genvar j = 0; j < LANES; j++) begin : g_l
            assign ln_src[k][j] = ln_ff[k-1][j];
         end
      end

      // shift in one numerator bit and try a subtract in each lane
      for (genvar j = 0; j < LANES; j++) begin : g_lane
         logic [REM_W-1:0] rem2;
         logic             take;
         assign rem2 = {ln_src[k][j].rem[REM_W-2:0], ln_src[k][j].num[QUO_W-1-k]};
         assign take = rem2 >= REM_W'(ctl_src[k].root);
         assign ln_in[j].rem = take ? rem2 - REM_W'(ctl_src[k].root) : rem2;
         assign ln_in[j].num = ln_src[k][j].num;
         assign ln_in[j].quo = {ln_src[k][j].quo[QUO_W-2:0], take};
         assign ln_in[j].neg = ln_src[k][j].neg;
      end

      // advance when enabled
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_src[k];
         end
         if (en) begin
            ctl_ff[k] <= ctl_src[k];
            for (int j = 0; j < LANES; j++) begin
               ln_ff[k][j] <= ln_in[j];
            end
         end
      end
   end

   assign out_valid        = v_ff[QUO_W-1];
   assign out_word.invalid = ctl_ff[QUO_W-1].invalid;
   assign out_word.sel     = ctl_ff[QUO_W-1].sel;
   assign out_word.root    = ctl_ff[QUO_W-1].root;
   assign out_word.neg0    = ln_ff[QUO_W-1][0].neg;
   assign out_word.neg1    = ln_ff[QUO_W-1][1].neg;
   assign out_word.neg2    = ln_ff[QUO_W-1][2].neg;
   assign out_word.quo0    = ln_ff[QUO_W-1][0].quo;
   assign out_word.quo1    = ln_ff[QUO_W-1][1].quo;
   assign out_word.quo2    = ln_ff[QUO_W-1][2].quo;

endmodule

### sv/rotation_matrix_to_quaternion_unit.sv
// Rotation matrix to quaternion converter. Takes one 3x3 matrix word per
// clock (Q1.14 elements) and returns the quaternion x, y, z, w in the same
// format, saturated, with an invalid flag (all components zero) when the
// square-root argument is not positive. Throughput is one word per cycle
// while req_ready is high. From accept to rsp_valid: one decode stage, 16
// square-root stages (one root bit each), 24 divider stages (one quotient
// bit each, three lanes) and the output register. A two-entry output buffer
// keeps req_ready high while one result waits on rsp_ready.
// Depends on rmq_pkg, rmq_front, rmq_sqrt and rmq_div.
module rotation_matrix_to_quaternion_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rmq_pkg::elem_type req_m_xx,
   input  rmq_pkg::elem_type req_m_xy,
   input  rmq_pkg::elem_type req_m_xz,
   input  rmq_pkg::elem_type req_m_yx,
   input  rmq_pkg::elem_type req_m_yy,
   input  rmq_pkg::elem_type req_m_yz,
   input  rmq_pkg::elem_type req_m_zx,
   input  rmq_pkg::elem_type req_m_zy,
   input  rmq_pkg::elem_type req_m_zz,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rmq_pkg::elem_type rsp_q_x,
   output rmq_pkg::elem_type rsp_q_y,
   output rmq_pkg::elem_type rsp_q_z,
   output rmq_pkg::elem_type rsp_q_w,
   output logic              rsp_invalid
);
   import rmq_pkg::*;

   logic       en;
   logic       front_v;
   front_type  front_w;
   logic       root_v;
   root_type   root_w;
   logic       div_v;
   div_type    div_w;
   result_type res_calc;
   logic       take;

   logic       out_v_ff, out_v_in;
   result_type out_ff, out_in;
   logic       skid_v_ff, skid_v_in;
   result_type skid_ff, skid_in;

   // stall the whole pipe only when the spare output entry is taken
   assign en        = !skid_v_ff;
   assign req_ready = en;

   rmq_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .m_xx     (req_m_xx),
      .m_xy     (req_m_xy),
      .m_xz     (req_m_xz),
      .m_yx     (req_m_yx),
      .m_yy     (req_m_yy),
      .m_yz     (req_m_yz),
      .m_zx     (req_m_zx),
      .m_zy     (req_m_zy),
      .m_zz     (req_m_zz),
      .out_valid(front_v),
      .out_word (front_w)
   );

   rmq_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (front_v),
      .in_word  (front_w),
      .out_valid(root_v),
      .out_word (root_w)
   );

   rmq_div u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (root_v),
      .in_word  (root_w),
      .out_valid(div_v),
      .out_word (div_w)
   );

   assign res_calc = build_result(div_w);
   assign take     = out_v_ff && rsp_ready;

   // steer the finished word into the output register or the spare entry
   always_comb begin
      out_v_in  = out_v_ff;
      out_in    = out_ff;
      skid_v_in = skid_v_ff;
      skid_in   = skid_ff;
      if (take || !out_v_ff) begin
         if (skid_v_ff) begin
            out_v_in  = 1'b1;
            out_in    = skid_ff;
            skid_v_in = 1'b0;
         end else begin
            out_v_in = en && div_v;
            out_in   = res_calc;
         end
      end else if (en && div_v) begin
         skid_v_in = 1'b1;
         skid_in   = res_calc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid   = out_v_ff;
   assign rsp_q_x     = out_ff.q_x;
   assign rsp_q_y     = out_ff.q_y;
   assign rsp_q_z     = out_ff.q_z;
   assign rsp_q_w     = out_ff.q_w;
   assign rsp_invalid = out_ff.invalid;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("spare entry filled while output register empty");

   a_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !rsp_ready && !skid_v_ff && div_v) |=> skid_v_ff)
      else $error("finished word dropped during output stall");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && out_ff.invalid) |->
         (out_ff.q_x == '0 && out_ff.q_y == '0 && out_ff.q_z == '0 && out_ff.q_w == '0))
      else $error("invalid word with nonzero components");

endmodule

### tb/sv/tb_rotation_matrix_to_quaternion_unit.sv
// Testbench for rotation_matrix_to_quaternion_unit: drives matrix words, predicts
// each quaternion word with its own fixed-point model and checks every response.
// Depends on rmq_pkg and the unit RTL.
`timescale 1ns / 100ps

module tb_rotation_matrix_to_quaternion_unit;
   import rmq_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int LATENCY     = 42;
   localparam elem_type MIN_E = 16'sh8000;

   typedef struct {
      logic [15:0] qx, qy, qz, qw;
      logic        inv;
   } quat_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_ready;
   elem_type m [9] = '{default: '0};
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   elem_type rsp_q_x, rsp_q_y, rsp_q_z, rsp_q_w;
   logic     rsp_invalid;

   quat_type expected_quats [$];
   int       mismatches = 0;
   int       cycles = 0;
   int       rsp_hold = 0;
   bit       rsp_idle_off = 1'b0;

   rotation_matrix_to_quaternion_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_m_xx(m[0]), .req_m_xy(m[1]), .req_m_xz(m[2]),
      .req_m_yx(m[3]), .req_m_yy(m[4]), .req_m_yz(m[5]),
      .req_m_zx(m[6]), .req_m_zy(m[7]), .req_m_zz(m[8]),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_q_x(rsp_q_x), .rsp_q_y(rsp_q_y), .rsp_q_z(rsp_q_z), .rsp_q_w(rsp_q_w),
      .rsp_invalid(rsp_invalid)
   );

   always #1 clock = ~clock;

   // integer square root, floor
   function automatic longint unsigned int_sqrt(input longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint clamp16(input longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // d * 2^(FRAC-1) / r, nearest with halves away from zero
   function automatic longint scaled_term(input longint d, input longint unsigned r);
      longint unsigned mag, q;
      mag = (d < 0) ? longint'(-d) : d;
      q = ((mag << (FRAC_BITS - 1)) + (r >> 1)) / r;
      return (d < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic quat_type predict_quat(input elem_type e [9]);
      longint xx, xy, xz, yx, yy, yz, zx, zy, zz, tr, s, d0, d1, d2, h, c0, c1, c2;
      longint q [4];
      longint unsigned r;
      sel_type sel;
      quat_type w;
      xx = e[0]; xy = e[1]; xz = e[2]; yx = e[3]; yy = e[4];
      yz = e[5]; zx = e[6]; zy = e[7]; zz = e[8];
      tr = xx + yy + zz;
      if (tr > 0) begin
         sel = SEL_W; s = (1 << FRAC_BITS) + tr;
         d0 = zy - yz; d1 = xz - zx; d2 = yx - xy;
      end else if (xx > yy && xx > zz) begin
         sel = SEL_X; s = (1 << FRAC_BITS) + xx - yy - zz;
         d0 = yx + xy; d1 = xz + zx; d2 = zy - yz;
      end else if (yy > zz) begin
         sel = SEL_Y; s = (1 << FRAC_BITS) + yy - xx - zz;
         d0 = yx + xy; d1 = zy + yz; d2 = xz - zx;
      end else begin
         sel = SEL_Z; s = (1 << FRAC_BITS) + zz - xx - yy;
         d0 = xz + zx; d1 = zy + yz; d2 = yx - xy;
      end
      if (s <= 0) begin
         w.qx = '0; w.qy = '0; w.qz = '0; w.qw = '0; w.inv = 1'b1;
         return w;
      end
      r = int_sqrt(longint'(s) << FRAC_BITS);
      h = (r + 1) >> 1;
      c0 = scaled_term(d0, r); c1 = scaled_term(d1, r); c2 = scaled_term(d2, r);
      case (sel)
         SEL_W: begin q[0] = c0; q[1] = c1; q[2] = c2; q[3] = h; end
         SEL_X: begin q[0] = h; q[1] = c0; q[2] = c1; q[3] = c2; end
         SEL_Y: begin q[0] = c0; q[1] = h; q[2] = c1; q[3] = c2; end
         default: begin q[0] = c0; q[1] = c1; q[2] = h; q[3] = c2; end
      endcase
      w.qx = 16'(clamp16(q[0])); w.qy = 16'(clamp16(q[1]));
      w.qz = 16'(clamp16(q[2])); w.qw = 16'(clamp16(q[3]));
      w.inv = 1'b0;
      return w;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int gap_len();
      int p;
      p = $urandom_range(99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // send one matrix word and record its prediction
   task automatic send_matrix(input elem_type e [9], input bit idle);
      int g;
      g = idle ? gap_len() : 0;
      repeat (g) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      for (int k = 0; k < 9; k++) m[k] <= e[k];
      req_valid <= 1'b1;
      expected_quats.push_back(predict_quat(e));
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_idle_off();
      req_valid <= 1'b0;
   endtask

   // response readiness: stalls of random length, most short and a few long
   always @(negedge clock) begin
      if (reset || rsp_idle_off) begin
         rsp_ready <= 1'b1;
         rsp_hold = 0;
      end else if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold = rsp_hold - 1;
      end else if ($urandom_range(99) < 30) begin
         rsp_ready <= 1'b0;
         rsp_hold = gap_len();
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // check each response word against the oldest prediction
   always @(posedge clock) begin
      quat_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_quats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response word at cycle %0d", cycles);
         end else begin
            w = expected_quats.pop_front();
            if (rsp_q_x !== w.qx || rsp_q_y !== w.qy || rsp_q_z !== w.qz ||
                rsp_q_w !== w.qw || rsp_invalid !== w.inv) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp %0d %0d %0d %0d inv %b, got %0d %0d %0d %0d inv %b",
                           $signed(w.qx), $signed(w.qy), $signed(w.qz), $signed(w.qw), w.inv,
                           rsp_q_x, rsp_q_y, rsp_q_z, rsp_q_w, rsp_invalid);
            end
         end
      end
   end

   // hard stop on a hang
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic elem_type rand_elem();
      return elem_type'($urandom_range(65535));
   endfunction

   // build a rotation-like matrix: random diagonal, antisymmetric xy pair and signed noise
   function automatic void near_rotation(output elem_type e [9]);
      int diag, noise;
      noise = $urandom_range(3) == 0 ? 2000 : 60;
      for (int k = 0; k < 9; k++)
         e[k] = elem_type'(int'($urandom_range(2 * noise)) - noise);
      for (int k = 0; k < 9; k += 4) begin
         diag = int'($urandom_range(32767)) - 16384;
         e[k] = elem_type'(diag);
      end
      e[1] = elem_type'(int'($urandom_range(32767)) - 16384);
      e[3] = elem_type'(-e[1] + e[3]);
   endfunction

   // extremes, each branch, ties and saturation
   task automatic test_directed();
      elem_type e [9];
      for (int k = 0; k < 9; k++) e[k] = 16'sd0;
      e[0] = 16'sd16384; e[4] = 16'sd16384; e[8] = 16'sd16384;
      send_matrix(e, 1'b0);
      e[4] = -16'sd16384; e[8] = -16'sd16384;
      send_matrix(e, 1'b0);
      e[0] = -16'sd16384; e[4] = 16'sd16384;
      send_matrix(e, 1'b0);
      e[4] = -16'sd16384; e[8] = 16'sd16384;
      send_matrix(e, 1'b0);
      // ties on the diagonal
      e[0] = -16'sd100; e[4] = -16'sd100; e[8] = -16'sd200;
      send_matrix(e, 1'b0);
      e[8] = -16'sd100;
      send_matrix(e, 1'b0);
      // extreme diagonal values
      e[0] = MIN_E; e[4] = 16'sd32767; e[8] = 16'sd32767;
      send_matrix(e, 1'b0);
      for (int k = 0; k < 9; k++) e[k] = MIN_E;
      send_matrix(e, 1'b0);
      for (int k = 0; k < 9; k++) e[k] = 16'sd32767;
      send_matrix(e, 1'b0);
      // extreme off-diagonal elements with a large root, then smaller roots, up to the output limits
      for (int k = 0; k < 9; k++) e[k] = 16'sd0;
      e[0] = -16'sd16383; e[4] = -16'sd16383; e[8] = 16'sd16383;
      e[1] = 16'sd32767; e[3] = MIN_E; e[2] = 16'sd32767; e[6] = 16'sd32767;
      e[5] = MIN_E; e[7] = MIN_E;
      send_matrix(e, 1'b0);
      e[1] = MIN_E; e[3] = 16'sd32767; e[2] = MIN_E; e[6] = MIN_E;
      e[5] = 16'sd32767; e[7] = 16'sd32767;
      send_matrix(e, 1'b0);
      e[0] = 16'sd1; e[4] = 16'sd0; e[8] = -16'sd1;
      send_matrix(e, 1'b0);
      e[0] = 16'sd0; e[8] = 16'sd0;
      send_matrix(e, 1'b0);
   endtask

   // mostly near-rotations, some raw noise
   task automatic test_random(input int count);
      elem_type e [9];
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 75) near_rotation(e);
         else for (int k = 0; k < 9; k++) e[k] = rand_elem();
         send_matrix(e, 1'b1);
      end
   endtask

   // back-to-back words with the response side always ready
   task automatic test_full_rate(input int count);
      elem_type e [9];
      rsp_idle_off = 1'b1;
      for (int n = 0; n < count; n++) begin
         near_rotation(e);
         send_matrix(e, 1'b0);
      end
      rsp_idle_off = 1'b0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_rate(150);
      test_random(1250);
      send_idle_off();
      while (expected_quats.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0 && expected_quats.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
